### rtl/frame_bitmap_allocator_unit_defines.svh
// Assertion macros used by the allocator's top-level RTL file.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

`define FBA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fba_pkg.sv
package fba_pkg;

	localparam int NUM_FRAMES_DEF = 4096;
	localparam int WORD_BITS_DEF  = 32;
	localparam int FRAME_W        = 12;
	localparam int FIELD_FRAMES   = 4096;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_FORCE = 2'd2;
	localparam logic [1:0] REQ_TEST  = 2'd3;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_ALREADY   = 2'd1;
	localparam logic [1:0] STATUS_NO_FREE   = 2'd2;
	localparam logic [1:0] STATUS_NOT_ALLOC = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [FRAME_W-1:0] frame_number;
		logic               is_user;
		logic               is_writable;
	} request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FRAME_W-1:0] result_frame;
		logic               present;
		logic               writable;
		logic               user_page;
		logic               in_use;
	} result_t;

endpackage

### rtl/fba_bitmap_ram.sv
module fba_bitmap_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/frame_bitmap_allocator_unit.sv
// First-fit page-frame allocator with one used bit per frame.
// The request channel (request_valid, request_stall, request) carries one
// request: allocate, free, force mark used or test. The result channel
// (result_valid, result_stall, result) returns exactly one result for each
// request, in order. A request is taken when valid is high and stall is low.
// The bitmap sits in a single-port-write, single-port-read RAM of
// ceil(min(NUM_FRAMES, 4096) / WORD_BITS) words with registered reads.
// Free, force and test of a frame in range go through decode, address,
// modify and done; one that needs no bitmap access skips to done.
// Allocate reads one bitmap word per cycle from word 0 until it meets a word
// that is not full; if even the last word is full it reports no free frame.
// One request is worked on at a time; the next request is accepted as soon
// as the previous result has moved to the output register, even if the
// receiver is still stalling it.
// After reset the block clears the bitmap one word per cycle, from word 0
// to the last word, and holds request_stall high meanwhile.
// While result_stall is high the result stays in the output register and
// the block finishes at most one further request before it waits too.
`include "frame_bitmap_allocator_unit_defines.svh"

module frame_bitmap_allocator_unit #(
	parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF,
	parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              request_valid,
	output logic              request_stall,
	input  fba_pkg::request_t request,
	output logic              result_valid,
	input  logic              result_stall,
	output fba_pkg::result_t  result
);

	localparam int FW  = fba_pkg::FRAME_W;
	localparam int EFF_FRAMES =
		(NUM_FRAMES < fba_pkg::FIELD_FRAMES) ? NUM_FRAMES : fba_pkg::FIELD_FRAMES;
	localparam int DEPTH = (EFF_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = AW + 1;
	localparam int BW  = $clog2(WORD_BITS);
	localparam int SH  = FW + BW;
	localparam int PW  = SH + FW;
	localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int LAST_BITS = EFF_FRAMES - (DEPTH - 1) * WORD_BITS;

	localparam logic [PW-1:0]        RECIP_L   = PW'(RECIP);
	localparam logic [FW:0]          EFF_L     = (FW + 1)'(EFF_FRAMES);
	localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [CW-1:0]        DEPTH_L   = CW'(DEPTH);
	localparam logic [FW-1:0]        WB_L      = FW'(WORD_BITS);
	localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} << LAST_BITS;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_ADR  = 3'd3;
	localparam logic [2:0] S_MOD  = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	function automatic logic [BW-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [BW-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BW'(i);
			end
		end
		return idx;
	endfunction

	logic [2:0]           state_q, state_d;
	logic [AW-1:0]        clr_q;
	logic [CW-1:0]        scan_addr_q;
	logic                 chk_valid_s1;
	logic [AW-1:0]        chk_addr_s1;
	logic                 out_valid_q;
	fba_pkg::result_t     out_q;
	fba_pkg::request_t    req_q;
	fba_pkg::result_t     res_q, res_d;
	logic                 res_load;
	logic [AW-1:0]        word_q;
	logic [BW-1:0]        bit_q;

	logic                 accept;
	logic                 out_load;
	logic                 scan_issue;
	logic                 in_range;
	logic [PW-1:0]        prod;
	logic [FW-1:0]        quot;
	logic [FW-1:0]        rem;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] scan_word;
	logic                 scan_full;
	logic [BW-1:0]        free_bit;
	logic [FW-1:0]        found_frame;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	fba_bitmap_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.WIDTH (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign request_stall = (state_q != S_IDLE);
	assign accept        = request_valid && !request_stall;
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || !result_stall);
	assign result_valid  = out_valid_q;
	assign result        = out_q;

	// Division by the word size through a reciprocal that is exact for 12-bit frames.
	assign in_range = {1'b0, req_q.frame_number} < EFF_L;
	assign prod     = PW'(req_q.frame_number) * RECIP_L;
	assign quot     = prod[PW-1:SH];
	assign rem      = req_q.frame_number - FW'({{(FW-AW){1'b0}}, word_q} * WB_L);
	assign bit_mask = WORD_BITS'(1) << bit_q;

	assign scan_issue  = scan_addr_q < DEPTH_L;
	assign scan_word   = mem_rdata | ((chk_addr_s1 == LAST_ADDR) ? LAST_MASK : '0);
	assign scan_full   = &scan_word;
	assign free_bit    = first_zero(scan_word);
	assign found_frame = FW'({{(FW-AW){1'b0}}, chk_addr_s1} * WB_L) + FW'(free_bit);

	assign mem_raddr = (state_q == S_SCAN) ? scan_addr_q[AW-1:0] : word_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = word_q;
		mem_wdata = '0;
		res_d     = '0;
		res_load  = 1'b0;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				res_load = 1'b1;
				state_d  = S_DONE;
				case (req_q.req_type)
					fba_pkg::REQ_ALLOC: begin
						if (req_q.frame_number != '0) begin
							res_d.status       = fba_pkg::STATUS_ALREADY;
							res_d.result_frame = req_q.frame_number;
						end else begin
							res_load = 1'b0;
							state_d  = S_SCAN;
						end
					end
					fba_pkg::REQ_FREE: begin
						if (req_q.frame_number == '0) begin
							res_d.status = fba_pkg::STATUS_NOT_ALLOC;
						end else if (in_range) begin
							res_load = 1'b0;
							state_d  = S_ADR;
						end
					end
					fba_pkg::REQ_FORCE: begin
						res_d.result_frame = req_q.frame_number;
						res_d.present      = 1'b1;
						res_d.writable     = req_q.is_writable;
						res_d.user_page    = req_q.is_user;
						if (in_range) begin
							res_load = 1'b0;
							state_d  = S_ADR;
						end
					end
					default: begin
						res_d.result_frame = req_q.frame_number;
						if (in_range) begin
							res_load = 1'b0;
							state_d  = S_ADR;
						end
					end
				endcase
			end
			S_ADR: begin
				state_d = S_MOD;
			end
			S_MOD: begin
				res_load = 1'b1;
				state_d  = S_DONE;
				case (req_q.req_type)
					fba_pkg::REQ_FREE: begin
						mem_we    = 1'b1;
						mem_wdata = mem_rdata & ~bit_mask;
					end
					fba_pkg::REQ_FORCE: begin
						mem_we             = 1'b1;
						mem_wdata          = mem_rdata | bit_mask;
						res_d.result_frame = req_q.frame_number;
						res_d.present      = 1'b1;
						res_d.writable     = req_q.is_writable;
						res_d.user_page    = req_q.is_user;
					end
					fba_pkg::REQ_TEST: begin
						res_d.result_frame = req_q.frame_number;
						res_d.in_use       = |(mem_rdata & bit_mask);
					end
					default: begin
						res_load = 1'b0;
						state_d  = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if (chk_valid_s1) begin
					if (!scan_full) begin
						mem_we             = 1'b1;
						mem_waddr          = chk_addr_s1;
						mem_wdata          = mem_rdata | (WORD_BITS'(1) << free_bit);
						res_d.result_frame = found_frame;
						res_d.present      = 1'b1;
						res_d.writable     = req_q.is_writable;
						res_d.user_page    = req_q.is_user;
						res_load           = 1'b1;
						state_d            = S_DONE;
					end else if (chk_addr_s1 == LAST_ADDR) begin
						res_d.status = fba_pkg::STATUS_NO_FREE;
						res_load     = 1'b1;
						state_d      = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			scan_addr_q  <= '0;
			chk_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == S_DEC) begin
				scan_addr_q <= '0;
			end else if (state_q == S_SCAN && scan_issue) begin
				scan_addr_q <= scan_addr_q + CW'(1);
			end
			chk_valid_s1 <= (state_q == S_SCAN) && scan_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (state_q == S_DEC) begin
			word_q <= quot[AW-1:0];
		end
		if (state_q == S_ADR) begin
			bit_q <= rem[BW-1:0];
		end
		chk_addr_s1 <= scan_addr_q[AW-1:0];
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	`FBA_ASSERT_NEXT(a_accept_decodes, accept, state_q == S_DEC,
		"An accepted request was not decoded in the next cycle.")
	`FBA_ASSERT_SAME(a_write_states, mem_we,
		state_q == S_CLR || state_q == S_MOD || state_q == S_SCAN,
		"The bitmap was written outside the clear, modify or scan steps.")
	`FBA_ASSERT_NEXT(a_scan_write_ends, (state_q == S_SCAN) && mem_we, state_q == S_DONE,
		"An allocation write did not end the scan.")
	`FBA_ASSERT_NEXT(a_result_handover, out_load, out_valid_q && state_q == S_IDLE,
		"A finished result did not reach the output register.")

endmodule

### tb/frame_bitmap_allocator_unit_test.sv
module frame_bitmap_allocator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fba_pkg::*;

	localparam int SEARCH_FRAMES = (NUM_FRAMES_DEF < FIELD_FRAMES) ? NUM_FRAMES_DEF : FIELD_FRAMES;
	localparam int MAP_WORDS = (NUM_FRAMES_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
	localparam int GAP_CAP = 40;
	localparam int STALL_CAP = 40;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_PER_PHASE = 160;

	class frame_usage_book;
		logic [WORD_BITS_DEF-1:0] used_words [MAP_WORDS];
		result_t awaited_results [$];
		int mismatch_count;

		function new();
			foreach (used_words[i]) used_words[i] = '0;
			mismatch_count = 0;
		endfunction

		function int lowest_free_frame();
			int w;
			int b;
			for (w = 0; w < MAP_WORDS; w++) begin
				if (w * WORD_BITS_DEF >= SEARCH_FRAMES) return -1;
				if (used_words[w] == '1) continue;
				for (b = 0; b < WORD_BITS_DEF; b++) begin
					if (w * WORD_BITS_DEF + b >= SEARCH_FRAMES) return -1;
					if (!used_words[w][b]) return w * WORD_BITS_DEF + b;
				end
			end
			return -1;
		endfunction

		function void note_request(request_t r);
			result_t e;
			int f;
			e = '0;
			f = r.frame_number;
			case (r.req_type)
				REQ_ALLOC: begin
					if (f != 0) begin
						e.status = STATUS_ALREADY;
						e.result_frame = r.frame_number;
					end else begin
						f = lowest_free_frame();
						if (f < 0) begin
							e.status = STATUS_NO_FREE;
						end else begin
							used_words[f / WORD_BITS_DEF][f % WORD_BITS_DEF] = 1'b1;
							e.status = STATUS_DONE;
							e.result_frame = f[FRAME_W-1:0];
							e.present = 1'b1;
							e.writable = r.is_writable;
							e.user_page = r.is_user;
						end
					end
				end
				REQ_FREE: begin
					if (f == 0) begin
						e.status = STATUS_NOT_ALLOC;
					end else begin
						if (f < NUM_FRAMES_DEF)
							used_words[f / WORD_BITS_DEF][f % WORD_BITS_DEF] = 1'b0;
						e.status = STATUS_DONE;
					end
				end
				REQ_FORCE: begin
					if (f < NUM_FRAMES_DEF)
						used_words[f / WORD_BITS_DEF][f % WORD_BITS_DEF] = 1'b1;
					e.status = STATUS_DONE;
					e.result_frame = r.frame_number;
					e.present = 1'b1;
					e.writable = r.is_writable;
					e.user_page = r.is_user;
				end
				default: begin
					e.status = STATUS_DONE;
					e.result_frame = r.frame_number;
					if (f < NUM_FRAMES_DEF)
						e.in_use = used_words[f / WORD_BITS_DEF][f % WORD_BITS_DEF];
				end
			endcase
			awaited_results.push_back(e);
		endfunction

		task report_mismatch(string what, int wanted, int seen);
			$display("Mismatch at %0t: %s expected %0d, got %0d", $realtime, what, wanted, seen);
			mismatch_count++;
		endtask

		task check_result(result_t got);
			result_t e;
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result, frame", -1, got.result_frame);
				return;
			end
			e = awaited_results.pop_front();
			if (got.status !== e.status) report_mismatch("status", e.status, got.status);
			if (got.result_frame !== e.result_frame)
				report_mismatch("result_frame", e.result_frame, got.result_frame);
			if (got.present !== e.present) report_mismatch("present", e.present, got.present);
			if (got.writable !== e.writable) report_mismatch("writable", e.writable, got.writable);
			if (got.user_page !== e.user_page)
				report_mismatch("user_page", e.user_page, got.user_page);
			if (got.in_use !== e.in_use) report_mismatch("in_use", e.in_use, got.in_use);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic request_valid = 1'b0;
	logic request_stall;
	request_t request = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	frame_usage_book book = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int stall_run = 0;
	int quiet_cycles = 0;

	always #6 clk = ~clk;

	frame_bitmap_allocator_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request(request),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_stall === 1'b0) book.check_result(result);
		if (stall_run < STALL_CAP && $urandom_range(99) < recv_stall_pct) begin
			result_stall <= 1'b1;
			stall_run++;
		end else begin
			result_stall <= 1'b0;
			stall_run = 0;
		end
	end

	always @(posedge clk) begin
		if ((request_valid && request_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic request_t make_request(logic [1:0] kind, logic [FRAME_W-1:0] frame,
			logic user, logic rw);
		request_t r;
		r.req_type = kind;
		r.frame_number = frame;
		r.is_user = user;
		r.is_writable = rw;
		return r;
	endfunction

	function automatic logic [FRAME_W-1:0] pick_frame();
		if ($urandom_range(1)) return FRAME_W'($urandom_range(FIELD_FRAMES - 1));
		return FRAME_W'($urandom_range(255));
	endfunction

	function automatic request_t random_request();
		request_t r;
		int roll;
		roll = $urandom_range(99);
		r.is_user = 1'($urandom_range(1));
		r.is_writable = 1'($urandom_range(1));
		if (roll < 40) begin
			r.req_type = REQ_ALLOC;
			r.frame_number = ($urandom_range(99) < 85) ? '0 : pick_frame();
		end else if (roll < 65) begin
			r.req_type = REQ_FREE;
			r.frame_number = pick_frame();
		end else if (roll < 80) begin
			r.req_type = REQ_FORCE;
			r.frame_number = pick_frame();
		end else begin
			r.req_type = REQ_TEST;
			r.frame_number = pick_frame();
		end
		return r;
	endfunction

	task automatic send_request(request_t r);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) begin
			request_valid <= 1'b0;
			@(posedge clk);
			gap++;
		end
		request_valid <= 1'b1;
		request <= r;
		do @(posedge clk); while (request_stall !== 1'b0);
		book.note_request(r);
	endtask

	initial begin
		int phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_request(make_request(REQ_TEST, 12'd0, 1'b0, 1'b0));
		send_request(make_request(REQ_ALLOC, 12'd0, 1'b1, 1'b1));
		send_request(make_request(REQ_ALLOC, 12'd0, 1'b0, 1'b0));
		send_request(make_request(REQ_ALLOC, 12'd4095, 1'b1, 1'b1));
		send_request(make_request(REQ_ALLOC, 12'd1, 1'b0, 1'b1));
		send_request(make_request(REQ_TEST, 12'd0, 1'b1, 1'b1));
		send_request(make_request(REQ_FREE, 12'd0, 1'b1, 1'b1));
		send_request(make_request(REQ_FREE, 12'd1, 1'b0, 1'b0));
		send_request(make_request(REQ_TEST, 12'd1, 1'b0, 1'b0));
		send_request(make_request(REQ_ALLOC, 12'd0, 1'b1, 1'b0));
		send_request(make_request(REQ_FORCE, 12'd4095, 1'b0, 1'b1));
		send_request(make_request(REQ_TEST, 12'd4095, 1'b0, 1'b0));
		send_request(make_request(REQ_FORCE, 12'd31, 1'b1, 1'b1));
		send_request(make_request(REQ_FORCE, 12'd32, 1'b0, 1'b0));
		send_request(make_request(REQ_TEST, 12'd32, 1'b0, 1'b0));
		send_request(make_request(REQ_FREE, 12'd4095, 1'b0, 1'b0));
		send_request(make_request(REQ_TEST, 12'd4095, 1'b1, 1'b0));
		send_request(make_request(REQ_FREE, 12'd2048, 1'b0, 1'b0));
		send_request(make_request(REQ_FORCE, 12'd0, 1'b1, 1'b0));
		send_request(make_request(REQ_ALLOC, 12'hAAA, 1'b0, 1'b1));
		send_request(make_request(REQ_ALLOC, 12'h555, 1'b1, 1'b0));
		send_request(make_request(REQ_TEST, 12'hAAA, 1'b0, 1'b0));
		send_request(make_request(REQ_FREE, 12'h555, 1'b1, 1'b1));
		send_request(make_request(REQ_ALLOC, 12'd0, 1'b0, 1'b0));

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 83;
				end
				default: begin
					send_idle_pct = 22;
					recv_stall_pct = 22;
				end
			endcase
			repeat (RANDOM_PER_PHASE) send_request(random_request());
		end
		request_valid <= 1'b0;

		while (book.awaited_results.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (book.mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
